### rtl/core/hot_list_flood_filter_unit_assert.svh
// Assertion macros for the hot-list flood filter checker.
// Needs nothing else; include by bare file name.
`ifndef HOT_LIST_FLOOD_FILTER_UNIT_ASSERT_SVH
`define HOT_LIST_FLOOD_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HLFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hlff: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HLFF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hlff: next-cycle check failed");

`endif

### rtl/core/hlff_pkg.sv
// Shared types and constants of the hot-list flood filter.
// No dependencies; imported by every module of the block.
package hlff_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int ADDR_W     = 32;
    localparam int SCORE_W    = 16;
    localparam int CNT_W      = 48;
    localparam int LEN_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int REASON_W   = 3;

    localparam logic [SCORE_W-1:0] DECAY_RST  = 16'd1;
    localparam logic [SCORE_W-1:0] BUMP_RST   = 16'd10;
    localparam logic [SCORE_W-1:0] THRESH_RST = 16'd100;
    localparam logic [LEN_W-1:0]   LENGTH_RST = 32'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY  = 2'd0,
        REG_BUMP   = 2'd1,
        REG_THRESH = 2'd2,
        REG_LENGTH = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CHK_ALLOW     = 2'd0,
        CHK_BLOCKED   = 2'd1,
        CHK_NEW_BLOCK = 2'd2
    } t_chk;

    typedef enum logic [REASON_W-1:0] {
        RSN_ALLOW       = 3'd0,
        RSN_SRC_BLOCKED = 3'd1,
        RSN_SRC_NEW     = 3'd2,
        RSN_DST_BLOCKED = 3'd3,
        RSN_DST_NEW     = 3'd4
    } t_reason;

    typedef struct packed {
        logic [SCORE_W-1:0] decay;
        logic [SCORE_W-1:0] bump;
        logic [SCORE_W-1:0] thresh;
        logic [LEN_W-1:0]   length;
    } t_cfg;

    typedef struct packed {
        logic find;
        logic update;
    } t_list_cmd;

    typedef struct packed {
        logic accept;
        logic src_find;
        logic src_upd;
        logic dst_find;
        logic dst_upd;
    } t_dp_cmd;

    typedef struct packed {
        logic src_deny;
    } t_dp_stat;

endpackage

### rtl/core/hlff_list.sv
// One hot list: a row of entry cells with decay, lookup and move-to-front.
// Depends on hlff_pkg.
module hlff_list import hlff_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_list_cmd         i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_cfg              i_cfg,
    input  logic [CNT_W-1:0]  i_count,
    output t_chk              o_chk
);

    logic               r_valid [LIST_DEPTH];
    logic [ADDR_W-1:0]  r_addr  [LIST_DEPTH];
    logic [SCORE_W-1:0] r_score [LIST_DEPTH];
    logic [CNT_W-1:0]   r_until [LIST_DEPTH];
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;

    logic               n_hit;
    logic [IDX_W-1:0]   n_hit_idx;
    logic [SCORE_W-1:0] h_score;
    logic [CNT_W-1:0]   h_until;
    logic [IDX_W-1:0]   pos;
    logic [SCORE_W:0]   sum;
    logic [SCORE_W-1:0] sat_sum;
    logic [SCORE_W-1:0] f_score;
    logic [CNT_W-1:0]   f_until;
    t_chk               chk;

    // Find the lowest valid entry holding the address
    always_comb begin
        n_hit     = 1'b0;
        n_hit_idx = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_addr[i] == i_addr)) begin
                n_hit     = 1'b1;
                n_hit_idx = IDX_W'(i);
            end
        end
    end

    // Work out the new front entry and the verdict
    always_comb begin
        h_score = r_score[r_hit_idx];
        h_until = r_until[r_hit_idx];
        pos     = r_hit ? r_hit_idx : IDX_W'(LIST_DEPTH - 1);
        sum     = {1'b0, h_score} + {1'b0, i_cfg.bump};
        sat_sum = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
        if (!r_hit) begin
            f_score = i_cfg.bump;
            f_until = '0;
            chk     = CHK_ALLOW;
        end else if (i_count <= h_until) begin
            f_score = h_score;
            f_until = h_until;
            chk     = CHK_BLOCKED;
        end else if (sat_sum >= i_cfg.thresh) begin
            f_score = '0;
            f_until = i_count + {{(CNT_W-LEN_W){1'b0}}, i_cfg.length};
            chk     = CHK_NEW_BLOCK;
        end else begin
            f_score = sat_sum;
            f_until = h_until;
            chk     = CHK_ALLOW;
        end
    end

    assign o_chk = chk;

    // Hold valid bits; front is always valid after an update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LIST_DEPTH; j++) begin
                r_valid[j] <= 1'b0;
            end
            r_hit <= 1'b0;
        end else begin
            if (i_cmd.find) begin
                r_hit <= n_hit;
            end
            if (i_cmd.update) begin
                r_valid[0] <= 1'b1;
                for (int j = 1; j < LIST_DEPTH; j++) begin
                    if (IDX_W'(j) <= pos) begin
                        r_valid[j] <= r_valid[j-1];
                    end
                end
            end
        end
    end

    // Decay scores on find; rotate entries on update
    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            r_hit_idx <= n_hit_idx;
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if (r_valid[i]) begin
                    r_score[i] <= (r_score[i] > i_cfg.decay) ? (r_score[i] - i_cfg.decay) : '0;
                end
            end
        end
        if (i_cmd.update) begin
            r_addr[0]  <= i_addr;
            r_score[0] <= f_score;
            r_until[0] <= f_until;
            for (int j = 1; j < LIST_DEPTH; j++) begin
                if (IDX_W'(j) <= pos) begin
                    r_addr[j]  <= r_addr[j-1];
                    r_score[j] <= r_score[j-1];
                    r_until[j] <= r_until[j-1];
                end
            end
        end
    end

endmodule

### rtl/core/hlff_datapath.sv
// Datapath: configuration registers, request counter, item latch, both lists, result.
// Depends on hlff_pkg and hlff_list.
module hlff_datapath import hlff_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]     i_src_ip,
    input  logic [ADDR_W-1:0]     i_dst_ip,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_allowed,
    output logic [REASON_W-1:0]   o_reason
);

    t_cfg              r_cfg;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_src;
    logic [ADDR_W-1:0] r_dst;
    logic              r_allowed;
    t_reason           r_reason;
    t_chk              src_chk;
    t_chk              dst_chk;
    t_list_cmd         src_cmd;
    t_list_cmd         dst_cmd;

    // Write configuration registers; unknown index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay  <= DECAY_RST;
            r_cfg.bump   <= BUMP_RST;
            r_cfg.thresh <= THRESH_RST;
            r_cfg.length <= LENGTH_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DECAY:  r_cfg.decay  <= i_cfg_data[SCORE_W-1:0];
                REG_BUMP:   r_cfg.bump   <= i_cfg_data[SCORE_W-1:0];
                REG_THRESH: r_cfg.thresh <= i_cfg_data[SCORE_W-1:0];
                REG_LENGTH: r_cfg.length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Count requests, wrapping at 48 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Latch the addresses of the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_src <= i_src_ip;
            r_dst <= i_dst_ip;
        end
    end

    assign src_cmd = '{find: i_cmd.src_find, update: i_cmd.src_upd};
    assign dst_cmd = '{find: i_cmd.dst_find, update: i_cmd.dst_upd};

    hlff_list u_src_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (src_cmd),
        .i_addr  (r_src),
        .i_cfg   (r_cfg),
        .i_count (r_count),
        .o_chk   (src_chk)
    );

    hlff_list u_dst_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dst_cmd),
        .i_addr  (r_dst),
        .i_cfg   (r_cfg),
        .i_count (r_count),
        .o_chk   (dst_chk)
    );

    // Capture the verdict of the list that decides the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.src_upd) begin
            r_allowed <= (src_chk == CHK_ALLOW);
            case (src_chk)
                CHK_BLOCKED:   r_reason <= RSN_SRC_BLOCKED;
                CHK_NEW_BLOCK: r_reason <= RSN_SRC_NEW;
                default:       r_reason <= RSN_ALLOW;
            endcase
        end else if (i_cmd.dst_upd) begin
            r_allowed <= (dst_chk == CHK_ALLOW);
            case (dst_chk)
                CHK_BLOCKED:   r_reason <= RSN_DST_BLOCKED;
                CHK_NEW_BLOCK: r_reason <= RSN_DST_NEW;
                default:       r_reason <= RSN_ALLOW;
            endcase
        end
    end

    assign o_stat.src_deny = (src_chk != CHK_ALLOW);
    assign o_allowed       = r_allowed;
    assign o_reason        = r_reason;

endmodule

### rtl/core/hlff_ctrl.sv
// Controller: sequences source find/update, then, unless the source is denied, destination find/update.
// Depends on hlff_pkg.
module hlff_ctrl import hlff_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC_FIND,
        ST_SRC_UPD,
        ST_DST_FIND,
        ST_DST_UPD
    } t_state;

    t_state r_state;
    logic   r_done;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);

    // Advance state; pulse done when a verdict is captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_SRC_FIND;
                    end
                end
                ST_SRC_FIND: r_state <= ST_SRC_UPD;
                ST_SRC_UPD: begin
                    if (i_stat.src_deny) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= ST_DST_FIND;
                    end
                end
                ST_DST_FIND: r_state <= ST_DST_UPD;
                ST_DST_UPD: begin
                    r_state <= ST_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Decode datapath commands from state
    assign o_cmd.accept   = accept;
    assign o_cmd.src_find = (r_state == ST_SRC_FIND);
    assign o_cmd.src_upd  = (r_state == ST_SRC_UPD);
    assign o_cmd.dst_find = (r_state == ST_DST_FIND);
    assign o_cmd.dst_upd  = (r_state == ST_DST_UPD);
    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = r_done;

endmodule

### rtl/core/hot_list_flood_filter_unit.sv
// Top level of the hot-list flood filter: controller plus datapath.
// Depends on hlff_pkg, hlff_ctrl and hlff_datapath.
//
// Raise start with the source and destination address while busy is low;
// the item is taken at that edge. Each list check runs in two steps in the list
// unit (decay and lookup, then move-to-front and verdict), and o_valid pulses for
// one cycle with o_allowed/o_reason after the source check when the source
// is denied, and after the destination check when that list is also checked.
// busy drops in the o_valid cycle, so the next item can start right then,
// but not before the last result shows. There is no backpressure on the result: the
// receiver must take it in that cycle. Write configuration only while idle.
module hot_list_flood_filter_unit import hlff_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]     i_src_ip,
    input  logic [ADDR_W-1:0]     i_dst_ip,
    output logic                  o_valid,
    output logic                  o_allowed,
    output logic [REASON_W-1:0]   o_reason
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    hlff_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    hlff_datapath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_src_ip   (i_src_ip),
        .i_dst_ip   (i_dst_ip),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_allowed  (o_allowed),
        .o_reason   (o_reason)
    );

endmodule

### rtl/core/hlff_checker.sv
// Port-level checks of the hot-list flood filter, bound to the top level.
// Depends on hlff_pkg and hot_list_flood_filter_unit_assert.svh.
`include "hot_list_flood_filter_unit_assert.svh"

module hlff_checker import hlff_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic                  o_allowed,
    input logic [REASON_W-1:0]   o_reason
);

    logic reason_ok;

    // Allowed exactly when the reason says so, and reason is a known code
    assign reason_ok = (o_allowed == (o_reason == RSN_ALLOW)) && (o_reason <= RSN_DST_NEW);

    // Accepted item keeps the block busy for the next cycle
    `HLFF_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)
    // Result shows while the block is ready for the next item
    `HLFF_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    // Result strobe lasts one cycle
    `HLFF_ASSERT_NXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    // Result fields are consistent
    `HLFF_ASSERT_IMP(a_reason_ok, i_clk, i_rst_n, o_valid, reason_ok)

endmodule

bind hot_list_flood_filter_unit hlff_checker u_hlff_checker (.*);
